### rtl/ccsaf_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and register codes for the center crop scaler.
// No dependencies; imported by every module of the block except ccsaf_ram.
package ccsaf_pkg;

    // Image store and output frame geometry
    localparam int MAX_SRC_PIXELS = 16777216;
    localparam int OUT_WIDTH      = 1280;
    localparam int OUT_HEIGHT     = 400;

    localparam int ADDR_W     = $clog2(MAX_SRC_PIXELS);
    localparam int LOAD_CNT_W = ADDR_W + 1;
    localparam int COL_W      = $clog2(OUT_WIDTH);
    localparam int ROW_W      = $clog2(OUT_HEIGHT);

    // Register fields
    localparam int SRC_W_W     = 13;
    localparam int SRC_H_W     = 12;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;
    localparam logic [SRC_W_W-1:0] SRC_WIDTH_RESET  = 13'd1280;
    localparam logic [SRC_H_W-1:0] SRC_HEIGHT_RESET = 12'd400;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SRC_HEIGHT = 2'd1;

    // Stream payload widths
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;
    localparam int PIX_W     = 32;
    localparam int CH_W      = 8;

    // Crop arithmetic for the 1280:400 = 16:5 aspect ratio.
    // x/5 for x < 81920 is (x*RECIP_5) >> RECIP_5_SHIFT.
    localparam int ASPECT_SHIFT       = 4;
    localparam int RECIP_5            = 52429;
    localparam int RECIP_5_SHIFT      = 18;
    // y/5 for y < 1024 and y/25 for y < 256, small operands
    localparam int RECIP_5_SMALL      = 205;
    localparam int RECIP_25_SMALL     = 41;
    localparam int RECIP_SMALL_SHIFT  = 10;
    // y/25 for y < 199728
    localparam int RECIP_25           = 167773;
    localparam int RECIP_25_SHIFT     = 22;
    // OUT_WIDTH = 5 << 8, OUT_HEIGHT = 25 << 4
    localparam int OW_SHIFT           = 8;
    localparam int OH_SHIFT           = 4;

    // Derived widths of the geometry values
    localparam int AREA_W   = SRC_W_W + SRC_H_W;
    localparam int PROD_W   = 23;
    localparam int CWDIV_W  = 3;
    localparam int CHDIV_W  = 4;
    localparam int CHW_W    = 17;
    localparam int SX_W     = SRC_W_W;
    localparam int BASE_W   = 27;

    // Geometry resync pipeline depth and its counter
    localparam int GEOM_LAT   = 8;
    localparam int SYNC_CNT_W = 4;

    // Flattening over a gray background: x/255 = (x*RECIP_255) >> 23, x < 66052
    localparam int BG_GRAY          = 240;
    localparam int ALPHA_MAX        = 255;
    localparam int NUM_W            = 16;
    localparam int RECIP_255        = 32897;
    localparam int RECIP_255_SHIFT  = 23;

    // Geometry and sampler start values from the resync pipeline
    typedef struct packed {
        logic [AREA_W-1:0]  area;
        logic [CWDIV_W-1:0] cw_div;
        logic [COL_W-1:0]   cw_mod;
        logic [ROW_W-1:0]   ch_mod;
        logic [CHW_W-1:0]   chw;
        logic [SX_W-1:0]    sx;
        logic [COL_W-1:0]   rem_x;
        logic [ROW_W-1:0]   rem_y;
        logic [BASE_W-1:0]  row_base;
    } geom_t;

    typedef enum logic [1:0] {
        EM_IDLE,
        EM_READ,
        EM_MIX,
        EM_DONE
    } emit_state_t;

endpackage

### rtl/center_crop_scaler_alpha_flatten_unit.sv
`timescale 1ns / 1ps
// Center crop nearest-neighbor scaler with alpha flattening, top level.
// Depends on ccsaf_pkg, ccsaf_ram, ccsaf_geom and ccsaf_blend.
//
// Input channel s_*: tuser[0] = 0 stores the RGBA word of tdata at the next
// raster position of the image store; tuser[0] = 1 asks for the next pixel of
// the 1280x400 output frame. Each request gives one item on m_*: gray-
// flattened blue, green, red in tdata, tlast on the frame's final pixel and
// tuser[0] set when the source image is not completely loaded yet.
// Loads stream at one item per cycle while s_tready is high. A request keeps
// s_tready low through the store read, two blend stages and the output load,
// so a new request is taken only after the last result enters the output
// register. Crop geometry and sampler start values come from a pipeline:
// s_tready stays low while it resyncs after reset, after each register write
// on cfg_* and after the last pixel of a frame. A stalled m_tready holds the
// result in the output register. Loads are still accepted while no request
// is in flight; a new request waits in EM_DONE until the result is taken.
// Reset clears the load count and frame position; the store is not cleared.
module center_crop_scaler_alpha_flatten_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    // config write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ccsaf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ccsaf_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ccsaf_pkg::S_TDATA_W-1:0]     s_tdata,   // in_red, in_green, in_blue, in_alpha
    input  logic                                s_tuser,   // mode
    // result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ccsaf_pkg::M_TDATA_W-1:0]     m_tdata,   // out_blue, out_green, out_red
    output logic                                m_tlast,   // frame_last
    output logic                                m_tuser    // not_loaded
);
    import ccsaf_pkg::*;

    localparam logic [SYNC_CNT_W-1:0] SYNC_START = SYNC_CNT_W'(GEOM_LAT + 1);

    // configuration and frame state
    logic [SRC_W_W-1:0]    src_width_reg,  src_width_next;
    logic [SRC_H_W-1:0]    src_height_reg, src_height_next;
    logic [LOAD_CNT_W-1:0] load_count_reg, load_count_next;
    logic [COL_W-1:0]      out_col_reg,    out_col_next;
    logic [ROW_W-1:0]      out_row_reg,    out_row_next;
    logic [SX_W-1:0]       sx_reg,         sx_next;
    logic [COL_W-1:0]      rem_x_reg,      rem_x_next;
    logic [ROW_W-1:0]      rem_y_reg,      rem_y_next;
    logic [BASE_W-1:0]     row_base_reg,   row_base_next;
    logic [SYNC_CNT_W-1:0] sync_cnt_reg,   sync_cnt_next;
    emit_state_t           state_reg,      state_next;

    // request flags and output register
    logic                  nl_reg;
    logic                  last_reg;
    logic                  oob_reg;
    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;
    logic                  m_tlast_reg;
    logic                  m_tuser_reg;

    geom_t                 geom;
    logic                  cfg_acc;
    logic                  in_acc;
    logic                  load_acc;
    logic                  emit_acc;
    logic                  loaded;
    logic                  store_full;
    logic                  frame_end;
    logic                  col_end;
    logic                  sync_idle;
    logic                  out_free;
    logic                  out_load;
    logic [BASE_W-1:0]     addr_sum;
    logic                  ram_en;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_addr;
    logic [PIX_W-1:0]      ram_rdata;
    logic [PIX_W-1:0]      blend_px;
    logic [CH_W-1:0]       blue;
    logic [CH_W-1:0]       green;
    logic [CH_W-1:0]       red;
    logic [COL_W:0]        rem_x_sum;
    logic [ROW_W:0]        rem_y_sum;
    logic                  carry_x;
    logic                  carry_y;

    assign cfg_ready  = 1'b1;
    assign cfg_acc    = cfg_valid & cfg_ready;
    assign in_acc     = s_tvalid & s_tready;
    assign load_acc   = in_acc & ~s_tuser;
    assign emit_acc   = in_acc & s_tuser;
    assign sync_idle  = (sync_cnt_reg == '0);
    assign out_free   = ~m_tvalid_reg | m_tready;

    assign loaded     = load_count_reg >= LOAD_CNT_W'(geom.area);
    assign store_full = load_count_reg >= LOAD_CNT_W'(MAX_SRC_PIXELS);
    assign col_end    = out_col_reg >= COL_W'(OUT_WIDTH - 1);
    assign frame_end  = col_end & (out_row_reg >= ROW_W'(OUT_HEIGHT - 1));
    assign addr_sum   = row_base_reg + BASE_W'(sx_reg);

    // incremental sampler steps
    assign rem_x_sum  = (COL_W + 1)'(rem_x_reg) + (COL_W + 1)'(geom.cw_mod);
    assign carry_x    = rem_x_sum >= (COL_W + 1)'(OUT_WIDTH);
    assign rem_y_sum  = (ROW_W + 1)'(rem_y_reg) + (ROW_W + 1)'(geom.ch_mod);
    assign carry_y    = rem_y_sum >= (ROW_W + 1)'(OUT_HEIGHT);

    // image store access
    assign ram_we   = load_acc & ~store_full;
    assign ram_en   = ram_we | (emit_acc & loaded);
    assign ram_addr = load_acc ? load_count_reg[ADDR_W-1:0] : addr_sum[ADDR_W-1:0];
    assign blend_px = oob_reg ? '0 : ram_rdata;

    ccsaf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_SRC_PIXELS)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (s_tdata),
        .rdata (ram_rdata)
    );

    ccsaf_geom u_geom (
        .clk        (clk),
        .src_width  (src_width_reg),
        .src_height (src_height_reg),
        .out_col    (out_col_reg),
        .out_row    (out_row_reg),
        .geom       (geom)
    );

    ccsaf_blend u_blend (
        .clk   (clk),
        .px    (blend_px),
        .blue  (blue),
        .green (green),
        .red   (red)
    );

    // request sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            EM_IDLE:
            begin
                if (emit_acc)
                begin
                    state_next = EM_READ;
                end
            end
            EM_READ: state_next = EM_MIX;
            EM_MIX:  state_next = EM_DONE;
            EM_DONE:
            begin
                if (out_free)
                begin
                    state_next = EM_IDLE;
                end
            end
            default: state_next = EM_IDLE;
        endcase
    end

    // request sequencer: outputs
    always_comb
    begin
        s_tready = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            EM_IDLE: s_tready = sync_idle;
            EM_DONE: out_load = out_free;
            default:
            begin
                s_tready = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    // registers, frame position, load count and sampler
    always_comb
    begin
        src_width_next  = src_width_reg;
        src_height_next = src_height_reg;
        load_count_next = load_count_reg;
        out_col_next    = out_col_reg;
        out_row_next    = out_row_reg;
        sx_next         = sx_reg;
        rem_x_next      = rem_x_reg;
        rem_y_next      = rem_y_reg;
        row_base_next   = row_base_reg;
        sync_cnt_next   = sync_cnt_reg;

        if (!sync_idle)
        begin
            sync_cnt_next = sync_cnt_reg - 1'b1;
        end

        // resync results are settled on the final count
        if (sync_cnt_reg == SYNC_CNT_W'(1))
        begin
            sx_next       = geom.sx;
            rem_x_next    = geom.rem_x;
            rem_y_next    = geom.rem_y;
            row_base_next = geom.row_base;
        end

        if (cfg_acc)
        begin
            sync_cnt_next = SYNC_START;
            case (cfg_index)
                CFG_SRC_WIDTH:  src_width_next  = cfg_data[SRC_W_W-1:0];
                CFG_SRC_HEIGHT: src_height_next = cfg_data[SRC_H_W-1:0];
                default:
                begin
                    src_width_next  = src_width_reg;
                    src_height_next = src_height_reg;
                end
            endcase
        end

        if (ram_we)
        begin
            load_count_next = load_count_reg + 1'b1;
        end

        if (emit_acc && loaded)
        begin
            if (frame_end)
            begin
                out_col_next    = '0;
                out_row_next    = '0;
                load_count_next = '0;
                sync_cnt_next   = SYNC_START;
            end
            else if (col_end)
            begin
                out_col_next  = '0;
                out_row_next  = out_row_reg + 1'b1;
                sx_next       = '0;
                rem_x_next    = '0;
                rem_y_next    = carry_y ? ROW_W'(rem_y_sum - (ROW_W + 1)'(OUT_HEIGHT))
                                        : ROW_W'(rem_y_sum);
                row_base_next = row_base_reg + BASE_W'(geom.chw)
                              + (carry_y ? BASE_W'(src_width_reg) : '0);
            end
            else
            begin
                out_col_next = out_col_reg + 1'b1;
                rem_x_next   = carry_x ? COL_W'(rem_x_sum - (COL_W + 1)'(OUT_WIDTH))
                                       : COL_W'(rem_x_sum);
                sx_next      = sx_reg + SX_W'(geom.cw_div) + SX_W'(carry_x);
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= SRC_WIDTH_RESET;
            src_height_reg <= SRC_HEIGHT_RESET;
            load_count_reg <= '0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
            sync_cnt_reg   <= SYNC_START;
            state_reg      <= EM_IDLE;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            src_width_reg  <= src_width_next;
            src_height_reg <= src_height_next;
            load_count_reg <= load_count_next;
            out_col_reg    <= out_col_next;
            out_row_reg    <= out_row_next;
            sync_cnt_reg   <= sync_cnt_next;
            state_reg      <= state_next;
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // sampler, request flags and result payload
    always_ff @(posedge clk)
    begin
        sx_reg       <= sx_next;
        rem_x_reg    <= rem_x_next;
        rem_y_reg    <= rem_y_next;
        row_base_reg <= row_base_next;
        if (emit_acc)
        begin
            nl_reg   <= ~loaded;
            last_reg <= loaded & frame_end;
            oob_reg  <= addr_sum >= BASE_W'(MAX_SRC_PIXELS);
        end
        if (out_load)
        begin
            m_tdata_reg <= nl_reg ? '0 : {red, green, blue};
            m_tlast_reg <= last_reg;
            m_tuser_reg <= nl_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

### rtl/ccsaf_ram.sv
`timescale 1ns / 1ps
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module ccsaf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, or read and hold the word until the next read
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/ccsaf_geom.sv
`timescale 1ns / 1ps
// Crop geometry and sampler start position, free-running eight-stage pipeline.
// Depends on ccsaf_pkg. Outputs are registered, the start values in stage 8.
module ccsaf_geom (
    input  logic                           clk,
    input  logic [ccsaf_pkg::SRC_W_W-1:0]  src_width,
    input  logic [ccsaf_pkg::SRC_H_W-1:0]  src_height,
    input  logic [ccsaf_pkg::COL_W-1:0]    out_col,
    input  logic [ccsaf_pkg::ROW_W-1:0]    out_row,
    output ccsaf_pkg::geom_t               geom
);
    import ccsaf_pkg::*;

    // stage 1
    logic [SRC_W_W-1:0] s1_w_reg;
    logic [SRC_H_W-1:0] s1_h_reg;
    logic [COL_W-1:0]   s1_col_reg;
    logic [ROW_W-1:0]   s1_row_reg;
    logic [AREA_W-1:0]  s1_area_reg;
    logic [PROD_W-1:0]  s1_wp_reg;
    logic [PROD_W-1:0]  s1_hp_reg;
    logic [15:0]        s1_h16_reg;
    logic [15:0]        s1_w5_reg;
    // stage 2
    logic [SRC_W_W-1:0] s2_w_reg;
    logic [SRC_H_W-1:0] s2_h_reg;
    logic [COL_W-1:0]   s2_col_reg;
    logic [ROW_W-1:0]   s2_row_reg;
    logic [AREA_W-1:0]  s2_area_reg;
    logic               s2_wider_reg;
    logic [31:0]        s2_q_reg;
    logic [15:0]        s2_w5_reg;
    // stage 3
    logic [SRC_W_W-1:0] s3_w_reg;
    logic [SRC_H_W-1:0] s3_h_reg;
    logic [COL_W-1:0]   s3_col_reg;
    logic [ROW_W-1:0]   s3_row_reg;
    logic [SRC_W_W-1:0] s3_cw_reg;
    logic [SRC_H_W-1:0] s3_ch_reg;
    // stage 4
    logic [SRC_W_W-1:0] s4_w_reg;
    logic [SRC_W_W-1:0] s4_cw_reg;
    logic [SRC_H_W-1:0] s4_ch_reg;
    logic [SRC_W_W-2:0] s4_ox_reg;
    logic [SRC_H_W-2:0] s4_oy_reg;
    logic [CWDIV_W-1:0] s4_cwdiv_reg;
    logic [CHDIV_W-1:0] s4_chdiv_reg;
    logic [23:0]        s4_pcol_reg;
    logic [20:0]        s4_prow_reg;
    // stage 5
    logic [SRC_W_W-1:0] s5_w_reg;
    logic [SRC_W_W-2:0] s5_ox_reg;
    logic [SRC_H_W-2:0] s5_oy_reg;
    logic [COL_W-1:0]   s5_cwmod_reg;
    logic [ROW_W-1:0]   s5_chmod_reg;
    logic [CHW_W-1:0]   s5_chw_reg;
    logic [23:0]        s5_pcol_reg;
    logic [20:0]        s5_prow_reg;
    logic [31:0]        s5_qx_reg;
    logic [34:0]        s5_qy_reg;
    // stage 6
    logic [SRC_W_W-1:0] s6_w_reg;
    logic [SRC_W_W-2:0] s6_ox_reg;
    logic [SRC_H_W-2:0] s6_oy_reg;
    logic [23:0]        s6_pcol_reg;
    logic [20:0]        s6_prow_reg;
    logic [SX_W-1:0]    s6_sx_reg;
    logic [12:0]        s6_sy_reg;
    // stage 7
    logic [SRC_W_W-2:0] s7_ox_reg;
    logic [SX_W-1:0]    s7_sx_reg;
    logic [COL_W-1:0]   s7_remx_reg;
    logic [ROW_W-1:0]   s7_remy_reg;
    logic [BASE_W-1:0]  s7_rowmul_reg;
    // stage 8
    logic [SX_W-1:0]    s8_sx_reg;
    logic [COL_W-1:0]   s8_remx_reg;
    logic [ROW_W-1:0]   s8_remy_reg;
    logic [BASE_W-1:0]  s8_base_reg;

    logic [SRC_W_W-1:0] dx;
    logic [SRC_H_W-1:0] dy;
    logic [12:0]        cwdiv_prod;
    logic [13:0]        chdiv_prod;
    logic [13:0]        row_idx;

    assign dx         = s3_w_reg - s3_cw_reg;
    assign dy         = s3_h_reg - s3_ch_reg;
    assign cwdiv_prod = 13'(s3_cw_reg[SRC_W_W-1:OW_SHIFT]) * 13'(RECIP_5_SMALL);
    assign chdiv_prod = 14'(s3_ch_reg[SRC_H_W-1:OH_SHIFT]) * 14'(RECIP_25_SMALL);
    assign row_idx    = 14'(s6_oy_reg) + 14'(s6_sy_reg);

    always_ff @(posedge clk)
    begin
        // area and aspect products
        s1_w_reg    <= src_width;
        s1_h_reg    <= src_height;
        s1_col_reg  <= out_col;
        s1_row_reg  <= out_row;
        s1_area_reg <= AREA_W'(src_width) * AREA_W'(src_height);
        s1_wp_reg   <= PROD_W'(src_width) * PROD_W'(OUT_HEIGHT);
        s1_hp_reg   <= PROD_W'(src_height) * PROD_W'(OUT_WIDTH);
        s1_h16_reg  <= {src_height, {ASPECT_SHIFT{1'b0}}};
        s1_w5_reg   <= 16'(src_width) * 16'd5;

        // which side is cropped, h*16/5 by reciprocal
        s2_w_reg     <= s1_w_reg;
        s2_h_reg     <= s1_h_reg;
        s2_col_reg   <= s1_col_reg;
        s2_row_reg   <= s1_row_reg;
        s2_area_reg  <= s1_area_reg;
        s2_wider_reg <= s1_wp_reg > s1_hp_reg;
        s2_q_reg     <= 32'(s1_h16_reg) * 32'(RECIP_5);
        s2_w5_reg    <= s1_w5_reg;

        // crop size
        s3_w_reg   <= s2_w_reg;
        s3_h_reg   <= s2_h_reg;
        s3_col_reg <= s2_col_reg;
        s3_row_reg <= s2_row_reg;
        s3_cw_reg  <= s2_wider_reg ? s2_q_reg[RECIP_5_SHIFT +: SRC_W_W] : s2_w_reg;
        s3_ch_reg  <= s2_wider_reg ? s2_h_reg : s2_w5_reg[15:ASPECT_SHIFT];

        // offsets, per-step quotients, position products
        s4_w_reg     <= s3_w_reg;
        s4_cw_reg    <= s3_cw_reg;
        s4_ch_reg    <= s3_ch_reg;
        s4_ox_reg    <= dx[SRC_W_W-1:1];
        s4_oy_reg    <= dy[SRC_H_W-1:1];
        s4_cwdiv_reg <= cwdiv_prod[RECIP_SMALL_SHIFT +: CWDIV_W];
        s4_chdiv_reg <= chdiv_prod[RECIP_SMALL_SHIFT +: CHDIV_W];
        s4_pcol_reg  <= 24'(s3_col_reg) * 24'(s3_cw_reg);
        s4_prow_reg  <= 21'(s3_row_reg) * 21'(s3_ch_reg);

        // per-step remainders, row stride, position quotients
        s5_w_reg     <= s4_w_reg;
        s5_ox_reg    <= s4_ox_reg;
        s5_oy_reg    <= s4_oy_reg;
        s5_cwmod_reg <= COL_W'(s4_cw_reg - 13'(s4_cwdiv_reg) * 13'(OUT_WIDTH));
        s5_chmod_reg <= ROW_W'(s4_ch_reg - 12'(s4_chdiv_reg) * 12'(OUT_HEIGHT));
        s5_chw_reg   <= CHW_W'(s4_chdiv_reg) * CHW_W'(s4_w_reg);
        s5_pcol_reg  <= s4_pcol_reg;
        s5_prow_reg  <= s4_prow_reg;
        s5_qx_reg    <= 32'(s4_pcol_reg[23:OW_SHIFT]) * 32'(RECIP_5);
        s5_qy_reg    <= 35'(s4_prow_reg[20:OH_SHIFT]) * 35'(RECIP_25);

        // source column and row of the current position
        s6_w_reg    <= s5_w_reg;
        s6_ox_reg   <= s5_ox_reg;
        s6_oy_reg   <= s5_oy_reg;
        s6_pcol_reg <= s5_pcol_reg;
        s6_prow_reg <= s5_prow_reg;
        s6_sx_reg   <= s5_qx_reg[RECIP_5_SHIFT +: SX_W];
        s6_sy_reg   <= s5_qy_reg[RECIP_25_SHIFT +: 13];

        // remainders and row start
        s7_ox_reg     <= s6_ox_reg;
        s7_sx_reg     <= s6_sx_reg;
        s7_remx_reg   <= COL_W'(s6_pcol_reg - 24'(s6_sx_reg) * 24'(OUT_WIDTH));
        s7_remy_reg   <= ROW_W'(s6_prow_reg - 21'(s6_sy_reg) * 21'(OUT_HEIGHT));
        s7_rowmul_reg <= BASE_W'(row_idx) * BASE_W'(s6_w_reg);

        s8_sx_reg   <= s7_sx_reg;
        s8_remx_reg <= s7_remx_reg;
        s8_remy_reg <= s7_remy_reg;
        s8_base_reg <= s7_rowmul_reg + BASE_W'(s7_ox_reg);
    end

    always_comb
    begin
        geom.area     = s2_area_reg;
        geom.cw_div   = s4_cwdiv_reg;
        geom.cw_mod   = s5_cwmod_reg;
        geom.ch_mod   = s5_chmod_reg;
        geom.chw      = s5_chw_reg;
        geom.sx       = s8_sx_reg;
        geom.rem_x    = s8_remx_reg;
        geom.rem_y    = s8_remy_reg;
        geom.row_base = s8_base_reg;
    end

endmodule

### rtl/ccsaf_blend.sv
`timescale 1ns / 1ps
// Alpha flattening of one RGBA word over gray, two register stages.
// Depends on ccsaf_pkg.
module ccsaf_blend (
    input  logic                         clk,
    input  logic [ccsaf_pkg::PIX_W-1:0]  px,
    output logic [ccsaf_pkg::CH_W-1:0]   blue,
    output logic [ccsaf_pkg::CH_W-1:0]   green,
    output logic [ccsaf_pkg::CH_W-1:0]   red
);
    import ccsaf_pkg::*;

    logic [NUM_W-1:0] num_reg [3];
    logic [31:0]      quot_reg [3];
    logic [CH_W-1:0]  alpha;
    logic [CH_W-1:0]  inv_alpha;
    logic [CH_W-1:0]  chan [3];

    assign alpha     = px[3*CH_W +: CH_W];
    assign inv_alpha = CH_W'(ALPHA_MAX) - alpha;
    // lane order: blue, green, red
    assign chan[0]   = px[2*CH_W +: CH_W];
    assign chan[1]   = px[CH_W +: CH_W];
    assign chan[2]   = px[0 +: CH_W];

    // c*a + 240*(255-a), then divide by 255 through the reciprocal
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            num_reg[i]  <= NUM_W'(chan[i]) * NUM_W'(alpha)
                         + NUM_W'(BG_GRAY) * NUM_W'(inv_alpha);
            quot_reg[i] <= 32'(num_reg[i]) * 32'(RECIP_255);
        end
    end

    assign blue  = quot_reg[0][RECIP_255_SHIFT +: CH_W];
    assign green = quot_reg[1][RECIP_255_SHIFT +: CH_W];
    assign red   = quot_reg[2][RECIP_255_SHIFT +: CH_W];

endmodule

### rtl/ccsaf_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the center crop scaler, bound to the top level.
// Depends on ccsaf_pkg and center_crop_scaler_alpha_flatten_unit.
module ccsaf_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [ccsaf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ccsaf_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [ccsaf_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                                s_tuser,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [ccsaf_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                                m_tlast,
    input  logic                                m_tuser
);
    import ccsaf_pkg::*;

    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
    else $error("result changed while stalled");

    // a not-loaded result carries no color and no frame end
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0 && !m_tlast)
    else $error("not-loaded result with pixel data");

    // a pixel request blocks the input while it is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
    else $error("input ready during a pixel request");

    // a register write starts a geometry resync
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !s_tready)
    else $error("input ready right after a register write");

endmodule

bind center_crop_scaler_alpha_flatten_unit ccsaf_checker u_checker (.*);
